### rtl/core/cxik_pkg.sv
// Shared types and constants for the CoreXY arm inverse kinematics block.
// Holds the configuration register indexes, the square-root step count and the CORDIC angle table.
// Depends on nothing.
package cxik_pkg;

  typedef enum logic [1:0] {
    REG_ARM_LENGTH      = 2'd0,
    REG_MIN_CARRIAGE_X  = 2'd1,
    REG_INV_GEAR_CIRCLE = 2'd2,
    REG_STEPS_SCALE     = 2'd3
  } cfg_reg_t;

  localparam int SQ_STEPS = 32;

  localparam logic signed [15:0] ANG_PI_Q13 = 16'sd25736;

  localparam logic [31:0] RST_ARM_LENGTH      = 32'd6553600;
  localparam logic [31:0] RST_INV_GEAR_CIRCLE = 32'd65536;
  localparam logic [31:0] RST_STEPS_SCALE     = 32'd131072;

  function automatic logic [30:0] atan_q30(input int unsigned i);
    logic [30:0] v;
    case (i)
      0: v = 31'd843314857;
      1: v = 31'd497837829;
      2: v = 31'd263043837;
      3: v = 31'd133525159;
      4: v = 31'd67021687;
      5: v = 31'd33543516;
      6: v = 31'd16775851;
      7: v = 31'd8388437;
      8: v = 31'd4194283;
      9: v = 31'd2097149;
      default: v = 31'd1 << (30 - i);
    endcase
    return v;
  endfunction

endpackage

### rtl/core/corexy_arm_inverse_kinematics_top.sv
// Top level of the CoreXY arm inverse kinematics block: point (x, y) in, alpha and beta out.
// Contains the square-root, CORDIC and scaling pipelines and the configuration registers.
// Depends on cxik_pkg.
//
// The block takes one target point per clock cycle while the output is not stalled and returns
// one result per point, in order. The square root resolves one result bit per stage over 32
// stages, and the CORDIC spends one stage per iteration. A stalled output holds the whole
// pipeline, so in_tready is low only while a result waits to be taken. Configuration writes
// take effect at once and are meant to happen while no point is in flight.
module corexy_arm_inverse_kinematics_top #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] target_x, [63:32] target_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] alpha_pos, [63:32] beta_pos
  output logic        out_tuser,  // [0] out_of_reach
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int SQ  = cxik_pkg::SQ_STEPS;
  localparam int CI  = CORDIC_ITERATIONS;
  localparam int LAT = SQ + CI + 8;

  logic [30:0]        arm_len_r;
  logic signed [31:0] min_x_r;
  logic [31:0]        inv_gear_r;
  logic [31:0]        scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_len_r  <= cxik_pkg::RST_ARM_LENGTH[30:0];
      min_x_r    <= 32'sd0;
      inv_gear_r <= cxik_pkg::RST_INV_GEAR_CIRCLE;
      scale_r    <= cxik_pkg::RST_STEPS_SCALE;
    end else if (cfg_we) begin
      case (cxik_pkg::cfg_reg_t'(cfg_addr))
        cxik_pkg::REG_ARM_LENGTH:      arm_len_r  <= cfg_wdata[30:0];
        cxik_pkg::REG_MIN_CARRIAGE_X:  min_x_r    <= $signed(cfg_wdata);
        cxik_pkg::REG_INV_GEAR_CIRCLE: inv_gear_r <= cfg_wdata;
        cxik_pkg::REG_STEPS_SCALE:     scale_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Stage 1: squares and reach check.
  logic signed [31:0] in_x, in_y;
  logic [32:0]        ay_w;
  logic signed [31:0] x1_r, y1_r;
  logic [61:0]        ll1_r, yy1_r;
  logic               oor1_r;
  logic [63:0]        yy_w;

  assign in_x = $signed(in_tdata[31:0]);
  assign in_y = $signed(in_tdata[63:32]);
  assign ay_w = in_y[31] ? (33'd0 - {1'b1, in_tdata[63:32]}) : {1'b0, in_tdata[63:32]};
  assign yy_w = ay_w[31:0] * ay_w[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= in_x;
      y1_r   <= in_y;
      ll1_r  <= arm_len_r * arm_len_r;
      yy1_r  <= yy_w[61:0];
      oor1_r <= ay_w > {2'b00, arm_len_r};
    end
  end

  // Side data travelling through the square root and the CORDIC.
  logic signed [31:0] sd_x_r   [0:SQ+CI];
  logic signed [31:0] sd_y_r   [0:SQ+CI];
  logic               sd_oor_r [0:SQ+CI];
  logic [61:0]        sq_rem_r [0:SQ];
  logic [63:0]        sq_root_r[0:SQ];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= ll1_r - yy1_r;
      sq_root_r[0] <= 64'd0;
      sd_x_r[0]    <= x1_r;
      sd_y_r[0]    <= y1_r;
      sd_oor_r[0]  <= oor1_r;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQ - 1 - k));
    logic [63:0] trial;
    logic        ge;
    assign trial = sq_root_r[k] + BIT;
    assign ge    = {2'b00, sq_rem_r[k]} >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1]  <= ge ? (sq_rem_r[k] - trial[61:0]) : sq_rem_r[k];
        sq_root_r[k+1] <= ge ? ((sq_root_r[k] >> 1) + BIT) : (sq_root_r[k] >> 1);
        sd_x_r[k+1]    <= sd_x_r[k];
        sd_y_r[k+1]    <= sd_y_r[k];
        sd_oor_r[k+1]  <= sd_oor_r[k];
      end
    end
  end

  // Vectoring CORDIC: atan2(y, c) in Q1.30.
  logic signed [35:0] cx_w [0:CI];
  logic signed [35:0] cy_w [0:CI];
  logic signed [33:0] z_w  [0:CI];
  logic [30:0]        c_w  [0:CI];
  logic signed [35:0] cx_r [1:CI];
  logic signed [35:0] cy_r [1:CI];
  logic signed [33:0] z_r  [1:CI];
  logic [30:0]        c_r  [1:CI];

  assign c_w[0]  = sq_root_r[SQ][30:0];
  assign cx_w[0] = $signed({5'b00000, sq_root_r[SQ][30:0]});
  assign cy_w[0] = 36'(sd_y_r[SQ]);
  assign z_w[0]  = 34'sd0;

  for (genvar j = 0; j < CI; j++) begin : g_cordic
    localparam logic signed [33:0] ATAN = $signed({3'b000, cxik_pkg::atan_q30(j)});
    logic signed [35:0] dx, dy;
    logic               up;
    assign dx = cy_w[j] >>> j;
    assign dy = cx_w[j] >>> j;
    assign up = cy_w[j] > 36'sd0;
    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[j+1]             <= up ? (cx_w[j] + dx) : (cx_w[j] - dx);
        cy_r[j+1]             <= up ? (cy_w[j] - dy) : (cy_w[j] + dy);
        z_r[j+1]              <= up ? (z_w[j] + ATAN) : (z_w[j] - ATAN);
        c_r[j+1]              <= c_w[j];
        sd_x_r[SQ+j+1]        <= sd_x_r[SQ+j];
        sd_y_r[SQ+j+1]        <= sd_y_r[SQ+j];
        sd_oor_r[SQ+j+1]      <= sd_oor_r[SQ+j];
      end
    end
    assign cx_w[j+1] = cx_r[j+1];
    assign cy_w[j+1] = cy_r[j+1];
    assign z_w[j+1]  = z_r[j+1];
    assign c_w[j+1]  = c_r[j+1];
  end

  // Stage M: angle rounding, carriage offset and mirrored solution.
  logic signed [33:0] zr_w;
  logic signed [15:0] ang0_w, ang_w;
  logic signed [34:0] off0_w, off_w, c2_w;
  logic               mir_w;
  logic signed [34:0] m_off_r;
  logic signed [15:0] m_ang_r;
  logic               m_oor_r;

  assign zr_w   = z_w[CI] + 34'sd65536;
  assign ang0_w = (sd_y_r[SQ+CI] == 32'sd0) ? 16'sd0 : 16'(zr_w >>> 17);
  assign c2_w   = $signed({4'b0000, c_w[CI]});
  assign off0_w = 35'(sd_x_r[SQ+CI]) - c2_w;
  assign mir_w  = off0_w < 35'(min_x_r);
  assign off_w  = mir_w ? (off0_w + c2_w + c2_w) : off0_w;
  assign ang_w  = !mir_w ? ang0_w :
                  (ang0_w > 16'sd0) ? (cxik_pkg::ANG_PI_Q13 - ang0_w) :
                  (-cxik_pkg::ANG_PI_Q13 - ang0_w);

  always_ff @(posedge clk) begin
    if (en) begin
      m_off_r <= off_w;
      m_ang_r <= ang_w;
      m_oor_r <= sd_oor_r[SQ+CI];
    end
  end

  // Stage P: angle times gear reciprocal.
  logic signed [48:0] p_prod_r;
  logic signed [34:0] p_off_r;
  logic               p_oor_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod_r <= 49'(m_ang_r) * 49'($signed({1'b0, inv_gear_r}));
      p_off_r  <= m_off_r;
      p_oor_r  <= m_oor_r;
    end
  end

  // Stage T: rounded term and the two sums.
  logic signed [48:0] term_w;
  logic signed [37:0] t_sa_r, t_sb_r;
  logic               t_oor_r;

  assign term_w = (p_prod_r + 49'sd4096) >>> 13;

  always_ff @(posedge clk) begin
    if (en) begin
      t_sa_r  <= 38'(p_off_r) + 38'(term_w);
      t_sb_r  <= 38'(p_off_r) - 38'(term_w);
      t_oor_r <= p_oor_r;
    end
  end

  // Stage U: sign and magnitude.
  logic [37:0] u_ma_r, u_mb_r;
  logic        u_na_r, u_nb_r, u_oor_r;

  always_ff @(posedge clk) begin
    if (en) begin
      u_na_r  <= t_sa_r[37];
      u_nb_r  <= t_sb_r[37];
      u_ma_r  <= t_sa_r[37] ? 38'(-t_sa_r) : 38'(t_sa_r);
      u_mb_r  <= t_sb_r[37] ? 38'(-t_sb_r) : 38'(t_sb_r);
      u_oor_r <= t_oor_r;
    end
  end

  // Stage Q: partial products with the scale.
  logic [53:0] q_ahi_r, q_alo_r, q_bhi_r, q_blo_r;
  logic        q_na_r, q_nb_r, q_oor_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_ahi_r <= u_ma_r * scale_r[31:16];
      q_alo_r <= u_ma_r * scale_r[15:0];
      q_bhi_r <= u_mb_r * scale_r[31:16];
      q_blo_r <= u_mb_r * scale_r[15:0];
      q_na_r  <= u_na_r;
      q_nb_r  <= u_nb_r;
      q_oor_r <= u_oor_r;
    end
  end

  function automatic logic [31:0] scale_sat(input logic [53:0] hi, input logic [53:0] lo,
                                           input logic neg);
    logic [54:0] r;
    logic [31:0] v;
    r = {1'b0, hi} + 55'(({1'b0, lo} + 55'd32768) >> 16);
    if (neg) begin
      v = (r >= 55'h80000000) ? 32'h80000000 : (32'd0 - r[31:0]);
    end else begin
      v = (r > 55'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
    end
    return v;
  endfunction

  // Stage O: output register.
  logic [31:0] o_alpha_r, o_beta_r;
  logic        o_oor_r;

  always_ff @(posedge clk) begin
    if (en) begin
      o_alpha_r <= q_oor_r ? 32'd0 : scale_sat(q_ahi_r, q_alo_r, q_na_r);
      o_beta_r  <= q_oor_r ? 32'd0 : scale_sat(q_bhi_r, q_blo_r, q_nb_r);
      o_oor_r   <= q_oor_r;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {o_beta_r, o_alpha_r};
  assign out_tuser  = o_oor_r;

endmodule

### rtl/core/cxik_checker.sv
// Port-level checks for the CoreXY arm inverse kinematics block, bound to its top level.
// Depends on corexy_arm_inverse_kinematics_top for the bind only.
module cxik_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Result changed while stalled.");

  a_reach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("Out-of-reach result carries non-zero positions.");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("Input held off while the output was free.");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("Input transfer taken while the output was stalled.");

endmodule

bind corexy_arm_inverse_kinematics_top cxik_checker u_cxik_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the CoreXY arm inverse kinematics block.
// Drives target points through the input stream, predicts alpha, beta and the reach flag
// in a scoreboard class, and checks each result transfer in order. Depends on cxik_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] alpha;
    logic [31:0] beta;
    logic        unreachable;
  } ik_result_t;

  class ik_scoreboard;
    logic [30:0] arm_len;
    logic signed [31:0] min_x;
    logic [31:0] inv_gear;
    logic [31:0] scale;
    ik_result_t pending[$];
    int mismatches;
    int checked;
    int unreachable_seen;
    int mirrored_seen;

    function new();
      arm_len = cxik_pkg::RST_ARM_LENGTH[30:0];
      min_x = 0;
      inv_gear = cxik_pkg::RST_INV_GEAR_CIRCLE;
      scale = cxik_pkg::RST_STEPS_SCALE;
      mismatches = 0;
      checked = 0;
      unreachable_seen = 0;
      mirrored_seen = 0;
    endfunction

    function void set_reg(cxik_pkg::cfg_reg_t idx, logic [31:0] v);
      case (idx)
        cxik_pkg::REG_ARM_LENGTH:      arm_len = v[30:0];
        cxik_pkg::REG_MIN_CARRIAGE_X:  min_x = v;
        cxik_pkg::REG_INV_GEAR_CIRCLE: inv_gear = v;
        cxik_pkg::REG_STEPS_SCALE:     scale = v;
        default: ;
      endcase
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic signed [63:0] arc_q30(logic signed [63:0] c, logic signed [63:0] y);
      logic signed [63:0] cx, cy, z, dx, dy;
      cx = c;
      cy = y;
      z = 0;
      for (int i = 0; i < 16; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + $signed({33'd0, cxik_pkg::atan_q30(i)});
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - $signed({33'd0, cxik_pkg::atan_q30(i)});
        end
      end
      return z;
    endfunction

    function logic [31:0] scale_sat(logic signed [63:0] s);
      logic [63:0] m, r;
      logic [63:0] hi, lo;
      m = (s < 0) ? -s : s;
      hi = {48'd0, scale[31:16]};
      lo = {48'd0, scale[15:0]};
      r = m * hi + ((m * lo + 64'h8000) >> 16);
      if (s < 0) begin
        if (r >= 64'h8000_0000) return 32'h8000_0000;
        return -r[31:0];
      end
      if (r > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return r[31:0];
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y);
      logic signed [63:0] lx, ly, ay, len, c, off, ang, term;
      ik_result_t r;
      lx = x;
      ly = y;
      len = {33'd0, arm_len};
      ay = (ly < 0) ? -ly : ly;
      if (ay > len) begin
        r = '{alpha: 0, beta: 0, unreachable: 1'b1};
      end else begin
        c = root_floor(len * len - ly * ly);
        ang = (ly == 0) ? 64'sd0 : ((arc_q30(c, ly) + (64'sd1 <<< 16)) >>> 17);
        off = lx - c;
        if (off < 64'(min_x)) begin
          off = off + 2 * c;
          ang = (ang > 0) ? 64'(cxik_pkg::ANG_PI_Q13) - ang :
                -64'(cxik_pkg::ANG_PI_Q13) - ang;
          mirrored_seen++;
        end
        term = (ang * $signed({32'd0, inv_gear}) + (64'sd1 <<< 12)) >>> 13;
        r = '{alpha: scale_sat(off + term), beta: scale_sat(off - term), unreachable: 1'b0};
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] data, logic flag);
      ik_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: data %h flag %b", data, flag);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (flag) unreachable_seen++;
      if (data[31:0] !== e.alpha || data[63:32] !== e.beta || flag !== e.unreachable) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: alpha %h/%h beta %h/%h reach %b/%b (expected/actual)",
                   e.alpha, data[31:0], e.beta, data[63:32], e.unreachable, flag);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  ik_scoreboard sb;
  int idle_cycles = 0;
  int unsigned points_sent = 0;

  localparam int WATCHDOG = 4000;
  localparam int LATENCY = 56;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  corexy_arm_inverse_kinematics_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Watchdog expired with %0d results outstanding", sb.pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, with quiet stretches of always-ready.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if ((points_sent / 200) % 3 == 1) gap = 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y);
    int gap;
    gap = ((points_sent / 150) % 4 == 2) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_point(x, y);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(cxik_pkg::cfg_reg_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] near_arm(logic [30:0] len);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = {1'b0, len};
      1: v = -{1'b0, len};
      2: v = {1'b0, len} + 1;
      3: v = 0;
      default: v = $urandom_range(0, 1) ? $urandom_range(0, len) : -$urandom_range(0, len);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] any_x(logic [30:0] len);
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom_range(0, 2 * len) - len;
    endcase
  endfunction

  initial begin
    logic [30:0] len;
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_point(32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h0);
    send_point(32'h8000_0000, 32'h0);
    send_point(32'h0064_0000, 32'h0064_0000);
    send_point(32'h0064_0000, 32'hFF9C_0000);
    send_point(32'h0, 32'h0064_0001);
    send_point(32'h0, 32'hFF9B_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'hFFF0_0000, 32'h0032_0000);
    send_point(32'hFFF0_0000, 32'hFFCE_0000);
    send_point(32'h0000_0001, 32'h0000_0001);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    write_reg(cxik_pkg::REG_ARM_LENGTH, 32'd0);
    write_reg(cxik_pkg::REG_STEPS_SCALE, 32'hFFFF_FFFF);
    send_point(32'h1234_5678, 32'h0);
    send_point(32'h8000_0000, 32'h0);
    send_point(32'h0, 32'h1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: len = 31'h7FFF_FFFF;
        1: len = 31'd1;
        2: len = 31'($urandom_range(1, 32'h7FFF_FFFF));
        default: len = 31'($urandom_range(32'h1_0000, 32'h0400_0000));
      endcase
      write_reg(cxik_pkg::REG_ARM_LENGTH, {1'b0, len});
      case (phase)
        0: write_reg(cxik_pkg::REG_MIN_CARRIAGE_X, 32'h8000_0000);
        1: write_reg(cxik_pkg::REG_MIN_CARRIAGE_X, 32'h7FFF_FFFF);
        default: write_reg(cxik_pkg::REG_MIN_CARRIAGE_X, $urandom_range(0, len) - len / 2);
      endcase
      case (phase)
        0: write_reg(cxik_pkg::REG_INV_GEAR_CIRCLE, 32'hFFFF_FFFF);
        1: write_reg(cxik_pkg::REG_INV_GEAR_CIRCLE, 32'd0);
        default: write_reg(cxik_pkg::REG_INV_GEAR_CIRCLE, $urandom());
      endcase
      case (phase)
        0: write_reg(cxik_pkg::REG_STEPS_SCALE, 32'd0);
        1: write_reg(cxik_pkg::REG_STEPS_SCALE, 32'hFFFF_FFFF);
        default: write_reg(cxik_pkg::REG_STEPS_SCALE, $urandom_range(0, 32'h0004_0000));
      endcase
      repeat (200) send_point(any_x(len), near_arm(len));
      drain();
    end

    drain();
    $display("Sent %0d target points over ten register settings; %0d results checked.",
             points_sent, sb.checked);
    $display("%0d results were out of reach and %0d used the mirrored solution.",
             sb.unreachable_seen, sb.mirrored_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/cxik_pkg.sv
rtl/core/corexy_arm_inverse_kinematics_top.sv
rtl/core/cxik_checker.sv
tb/tb_top.sv
